// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands, sampled on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/lzss_pkg.sv =====
// ----------------------------------------------------------------------------
// lzss_pkg
// Constants, widths and command/result types shared by the decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int WIN_LOG2   = 11;
  localparam int WIN_SIZE   = 1 << WIN_LOG2;
  localparam int PAIR_BITS  = 16;
  localparam int LEN_BITS   = PAIR_BITS - WIN_LOG2;
  localparam int MIN_COPY   = 3;
  localparam int MAX_COPY   = (1 << LEN_BITS) - 1 + MIN_COPY;
  localparam int CNT_W      = $clog2(MAX_COPY + 1);
  localparam int HDR_BYTES  = 4;
  localparam int HDR_W      = $clog2(HDR_BYTES + 1);
  localparam int TOKENS     = 8;
  localparam int TOK_W      = $clog2(TOKENS + 1);
  localparam int Q_LOG2     = 2;
  localparam int Q_DEPTH    = 1 << Q_LOG2;

  typedef logic [WIN_LOG2-1:0] win_addr_t;
  typedef logic [CNT_W-1:0]    copy_cnt_t;

  // One decoded token, handed from the front to the back.
  typedef struct packed {
    logic      is_copy;
    logic [7:0] lit_byte;
    win_addr_t src_addr;
    logic      src_ok;
    copy_cnt_t count;
    win_addr_t wr_addr;
    logic      stream_end;
  } cmd_t;

  // One output byte with its tags.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } res_t;

endpackage

// ===== design/lzss_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lzss_cmd_fifo
// Short queue of decoded tokens between the front and the back.
// ----------------------------------------------------------------------------
module lzss_cmd_fifo
  import lzss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  `include "assert_macros.svh"

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_LOG2-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_LOG2-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_LOG2:0]    cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (Q_LOG2+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_LOG2'(do_push);
    rd_ptr_nxt = rd_ptr_r + Q_LOG2'(do_pop);
    cnt_nxt    = cnt_r + (Q_LOG2+1)'(do_push) - (Q_LOG2+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_NEVER(cmdq_no_overflow, push && full, "token pushed into a full queue")
  `ASSERT_CLK(cmdq_ptr_gap, (cnt_r == '0 || cnt_r == (Q_LOG2+1)'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r), "queue count disagrees with pointers")

endmodule

// ===== design/lzss_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lzss_out_fifo
// Result queue that parts the back from the consumer of output bytes.
// ----------------------------------------------------------------------------
module lzss_out_fifo
  import lzss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  input  logic pop,
  output res_t head,
  output logic empty
);

  res_t               mem_r [Q_DEPTH];
  logic [Q_LOG2-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_LOG2-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_LOG2:0]    cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (Q_LOG2+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_LOG2'(do_push);
    rd_ptr_nxt = rd_ptr_r + Q_LOG2'(do_pop);
    cnt_nxt    = cnt_r + (Q_LOG2+1)'(do_push) - (Q_LOG2+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/lzss_front.sv =====
// ----------------------------------------------------------------------------
// lzss_front
// Parses header, flag and token bytes and issues literal/copy commands.
// ----------------------------------------------------------------------------
module lzss_front
  import lzss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  output logic       cmd_push,
  output cmd_t       cmd_data
);

  `include "assert_macros.svh"

  logic [HDR_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]      remain_r, remain_nxt;
  logic [31:0]      wcount_r, wcount_nxt;
  logic [7:0]       flag_r, flag_nxt;
  logic [TOK_W-1:0] tok_r, tok_nxt;
  logic [7:0]       pair_lo_r, pair_lo_nxt;
  logic             pend_r, pend_nxt;

  logic [PAIR_BITS-1:0] pair;
  win_addr_t            offset;
  copy_cnt_t            len;
  copy_cnt_t            cnt;
  logic                 len_covers;
  logic                 past_window;
  logic [31:0]          hdr_word;

  always_comb begin
    pair        = {in_data, pair_lo_r};
    offset      = pair[WIN_LOG2-1:0];
    len         = CNT_W'(pair[PAIR_BITS-1:WIN_LOG2]) + CNT_W'(MIN_COPY);
    len_covers  = (remain_r <= 32'(len));
    cnt         = len_covers ? remain_r[CNT_W-1:0] : len;
    past_window = (wcount_r > 32'(WIN_SIZE));
    hdr_word    = (hdr_cnt_r == '0) ? 32'(in_data)
                : (remain_r | (32'(in_data) << {hdr_cnt_r[1:0], 3'b000}));
  end

  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    remain_nxt  = remain_r;
    wcount_nxt  = wcount_r;
    flag_nxt    = flag_r;
    tok_nxt     = tok_r;
    pair_lo_nxt = pair_lo_r;
    pend_nxt    = pend_r;
    cmd_push    = 1'b0;
    cmd_data    = '0;
    cmd_data.wr_addr = wcount_r[WIN_LOG2-1:0];

    if (in_valid) begin
      if (hdr_cnt_r != HDR_W'(HDR_BYTES)) begin
        // header: accumulate the length little-endian
        remain_nxt  = hdr_word;
        hdr_cnt_nxt = hdr_cnt_r + HDR_W'(1);
        if (hdr_cnt_r == HDR_W'(HDR_BYTES - 1)) begin
          wcount_nxt = '0;
          tok_nxt    = TOK_W'(TOKENS);
          pend_nxt   = 1'b0;
          if (hdr_word == '0) begin
            hdr_cnt_nxt = '0;
          end
        end
      end else if (tok_r == TOK_W'(TOKENS)) begin
        flag_nxt = in_data;
        tok_nxt  = '0;
      end else if (pend_r) begin
        // second pair byte: issue a copy, cut at the declared length
        cmd_push            = 1'b1;
        cmd_data.is_copy    = 1'b1;
        cmd_data.count      = cnt;
        cmd_data.src_ok     = past_window || (32'(offset) < wcount_r);
        cmd_data.src_addr   = past_window ? (wcount_r[WIN_LOG2-1:0] + offset) : offset;
        cmd_data.stream_end = len_covers;
        pend_nxt   = 1'b0;
        tok_nxt    = tok_r + TOK_W'(1);
        wcount_nxt = wcount_r + 32'(cnt);
        remain_nxt = remain_r - 32'(cnt);
        if (len_covers) begin
          hdr_cnt_nxt = '0;
          tok_nxt     = TOK_W'(TOKENS);
        end
      end else if (!flag_r[tok_r[TOK_W-2:0]]) begin
        cmd_push            = 1'b1;
        cmd_data.lit_byte   = in_data;
        cmd_data.count      = CNT_W'(1);
        cmd_data.stream_end = (remain_r == 32'd1);
        tok_nxt    = tok_r + TOK_W'(1);
        wcount_nxt = wcount_r + 32'd1;
        remain_nxt = remain_r - 32'd1;
        if (remain_r == 32'd1) begin
          hdr_cnt_nxt = '0;
          tok_nxt     = TOK_W'(TOKENS);
        end
      end else begin
        pair_lo_nxt = in_data;
        pend_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= '0;
      remain_r  <= '0;
      wcount_r  <= '0;
      flag_r    <= '0;
      tok_r     <= TOK_W'(TOKENS);
      pend_r    <= 1'b0;
    end else begin
      hdr_cnt_r <= hdr_cnt_nxt;
      remain_r  <= remain_nxt;
      wcount_r  <= wcount_nxt;
      flag_r    <= flag_nxt;
      tok_r     <= tok_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pair_lo_r <= pair_lo_nxt;
  end

  `ASSERT_CLK(front_end_rearms, (cmd_push && cmd_data.stream_end) |=> (hdr_cnt_r == '0), "header not rearmed after stream end")
  `ASSERT_NEVER(front_body_has_room, (hdr_cnt_r == HDR_W'(HDR_BYTES)) && (remain_r == '0), "body open with nothing left to write")

endmodule

// ===== design/lzss_back.sv =====
// ----------------------------------------------------------------------------
// lzss_back
// Carries out literal and copy commands against the history ring.
// ----------------------------------------------------------------------------
module lzss_back
  import lzss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd_head,
  input  logic cmd_empty,
  output logic cmd_pop,
  output logic res_push,
  output res_t res_data,
  input  logic res_full
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_FETCH = 3'b001,
    ST_READ  = 3'b010,
    ST_EMIT  = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;
  win_addr_t   src_r, src_nxt;
  win_addr_t   wr_r, wr_nxt;
  copy_cnt_t   cnt_r, cnt_nxt;
  logic        ok_r, ok_nxt;
  logic        end_r, end_nxt;

  logic [7:0]  ring_mem [WIN_SIZE];
  logic [7:0]  rd_data_r;
  logic        rd_en;
  logic        wr_en;
  win_addr_t   wr_addr;
  logic        last_byte;

  assign last_byte = (cnt_r == CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    src_nxt   = src_r;
    wr_nxt    = wr_r;
    cnt_nxt   = cnt_r;
    ok_nxt    = ok_r;
    end_nxt   = end_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res_data  = '0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = wr_r;

    unique case (state_r)
      ST_FETCH: begin
        if (!cmd_empty) begin
          if (cmd_head.is_copy) begin
            cmd_pop   = 1'b1;
            src_nxt   = cmd_head.src_addr;
            wr_nxt    = cmd_head.wr_addr;
            cnt_nxt   = cmd_head.count;
            ok_nxt    = cmd_head.src_ok;
            end_nxt   = cmd_head.stream_end;
            state_nxt = ST_READ;
          end else if (!res_full) begin
            // literal goes straight out and into the ring
            cmd_pop             = 1'b1;
            res_push            = 1'b1;
            res_data.data       = cmd_head.lit_byte;
            res_data.run_last   = 1'b1;
            res_data.stream_end = cmd_head.stream_end;
            wr_en               = 1'b1;
            wr_addr             = cmd_head.wr_addr;
          end
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_full) begin
          res_push            = 1'b1;
          res_data.data       = ok_r ? rd_data_r : 8'd0;
          res_data.run_last   = last_byte;
          res_data.stream_end = last_byte && end_r;
          wr_en               = 1'b1;
          src_nxt             = src_r + WIN_LOG2'(1);
          wr_nxt              = wr_r + WIN_LOG2'(1);
          cnt_nxt             = cnt_r - CNT_W'(1);
          state_nxt           = last_byte ? ST_FETCH : ST_READ;
        end
      end
      default: state_nxt = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FETCH;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    wr_r  <= wr_nxt;
    cnt_r <= cnt_nxt;
    ok_r  <= ok_nxt;
    end_r <= end_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= res_data.data;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[src_r];
    end
  end

  `ASSERT_CLK(back_ring_tracks_out, wr_en == res_push, "ring write without a result byte")
  `ASSERT_CLK(back_last_frees, (res_push && res_data.run_last) |=> (state_r == ST_FETCH), "copy did not finish on its last byte")

endmodule

// ===== design/lzss_stream_decompressor.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS byte-stream decoder: 11-bit window, 5-bit length, length-prefixed.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                   Transfer when
//  -------  --------------------------------------  --------------------
//  input    in_push, in_full, in_byte               in_push && !in_full
//  result   out_pop, out_empty, out_byte,           out_pop && !out_empty
//           out_run_last, out_stream_end
//
//  A header, flag or first pair byte is taken and makes no result.
//  A literal leaves the back as soon as its token is fetched; a copy first
//  fetches its token, then for each output byte reads the history ring and
//  then emits, since the ring read is registered.
//  Reset clears control state only; the ring needs no clearing pass because
//  a copy from an entry not yet written in the current stream emits zeros.
//  Intake stalls only when the four-deep token queue is full; the back stalls
//  only when the four-deep result queue is full.
//
module lzss_stream_decompressor
  import lzss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_stream_end
);

  // Front to token queue
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;

  // Token queue to back
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;

  // Back to result queue
  logic res_push;
  res_t res_in;
  logic res_full;
  res_t res_head;

  // Hold intake whenever the token queue has no free slot, even for bytes
  // that would make no token.
  assign in_full = cmd_full;

  lzss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_push && !in_full),
    .in_data  (in_byte),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in)
  );

  lzss_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (cmd_empty)
  );

  lzss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  lzss_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .head      (res_head),
    .empty     (out_empty)
  );

  // Present the oldest waiting result.
  assign out_byte       = res_head.data;
  assign out_run_last   = res_head.run_last;
  assign out_stream_end = res_head.stream_end;

endmodule

// ===== test/lzss_stream_decompressor_tb.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_tb
// Self-checking bench for the length-prefixed LZSS stream decoder.
// Compressed streams are fed through the push/full port while a decode
// tracker follows the same bytes and queues the decoded output it implies.
// Each decoded byte popped from the block is checked against that queue:
// data, end-of-run tag and end-of-stream tag.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lzss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_TARGET = 200;
  localparam int unsigned DRAIN_CYCLES = 100;

  // What the decoder will make of the next compressed byte.
  typedef enum {
    ROLE_HDR,
    ROLE_FLAG,
    ROLE_LIT,
    ROLE_PAIR_LO,
    ROLE_PAIR_HI
  } byte_role_t;

  // Follows the compressed stream byte by byte and keeps the decoded bytes
  // still owed by the block, oldest first.
  class lzss_decode_book_t;
    logic [7:0]  ring [WIN_SIZE];
    logic [31:0] total_len;
    logic [31:0] written;
    logic [2:0]  hdr_cnt;
    logic [7:0]  flags;
    logic [3:0]  tok_idx;
    logic [7:0]  pair_lo;
    logic        pair_pend;
    res_t        run_bytes[$];
    res_t        owed_bytes[$];
    int unsigned fault_cnt;
    int unsigned checked_cnt;

    function new();
      foreach (ring[k]) ring[k] = 8'h00;
      total_len   = '0;
      written     = '0;
      hdr_cnt     = '0;
      flags       = '0;
      tok_idx     = 4'(TOKENS);
      pair_lo     = '0;
      pair_pend   = 1'b0;
      fault_cnt   = 0;
      checked_cnt = 0;
    endfunction

    function byte_role_t next_role();
      if (hdr_cnt < HDR_BYTES) return ROLE_HDR;
      if (tok_idx >= TOKENS) return ROLE_FLAG;
      if (pair_pend) return ROLE_PAIR_HI;
      return flags[tok_idx[2:0]] ? ROLE_PAIR_LO : ROLE_LIT;
    endfunction

    function void record(logic [7:0] v);
      res_t r;
      ring[written[WIN_LOG2-1:0]] = v;
      written = written + 1;
      r.data       = v;
      r.run_last   = 1'b0;
      r.stream_end = 1'b0;
      run_bytes.push_back(r);
    endfunction

    // Note one accepted compressed byte and queue what it decodes to.
    function void take_byte(logic [7:0] b);
      logic [15:0]       pair;
      longint unsigned   offs;
      longint unsigned   run_len;
      longint unsigned   base;
      longint unsigned   src;
      logic [7:0]        fetched;
      logic              done;
      res_t              r;
      run_bytes.delete();
      if (hdr_cnt < HDR_BYTES) begin
        if (hdr_cnt == 0) total_len = '0;
        total_len = total_len | (32'(b) << (8 * hdr_cnt));
        hdr_cnt = hdr_cnt + 1;
        if (hdr_cnt == HDR_BYTES) begin
          written   = '0;
          tok_idx   = 4'(TOKENS);
          pair_pend = 1'b0;
          if (total_len == 0) hdr_cnt = '0;
        end
        return;
      end
      if (tok_idx >= TOKENS) begin
        flags   = b;
        tok_idx = '0;
        return;
      end
      if (pair_pend) begin
        pair      = {b, pair_lo};
        offs      = pair[WIN_LOG2-1:0];
        run_len   = (pair >> WIN_LOG2) + MIN_COPY;
        base      = (written > WIN_SIZE) ? written - WIN_SIZE : 0;
        pair_pend = 1'b0;
        tok_idx   = tok_idx + 1;
        for (longint unsigned i = 0; i < run_len && written < total_len; i++) begin
          src = base + offs + i;
          fetched = (src < written) ? ring[src[WIN_LOG2-1:0]] : 8'h00;
          record(fetched);
        end
      end else if (!flags[tok_idx[2:0]]) begin
        tok_idx = tok_idx + 1;
        record(b);
      end else begin
        pair_lo   = b;
        pair_pend = 1'b1;
        return;
      end
      done = (written >= total_len);
      foreach (run_bytes[k]) begin
        r = run_bytes[k];
        if (k == run_bytes.size() - 1) begin
          r.run_last   = 1'b1;
          r.stream_end = done;
        end
        owed_bytes.push_back(r);
      end
      if (done) begin
        hdr_cnt   = '0;
        tok_idx   = 4'(TOKENS);
        pair_pend = 1'b0;
      end
    endfunction

    // Check one popped decoded byte against the oldest owed one.
    function void match_output(logic [7:0] d, logic rl, logic se);
      res_t got;
      res_t want;
      got.data       = d;
      got.run_last   = rl;
      got.stream_end = se;
      checked_cnt++;
      if (owed_bytes.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("ERROR: unowed output byte %02h last %0b end %0b", d, rl, se);
        return;
      end
      want = owed_bytes.pop_front();
      if (got !== want) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("ERROR: output %0d: expected byte %02h last %0b end %0b,%s",
                   checked_cnt, want.data, want.run_last, want.stream_end,
                   $sformatf(" got byte %02h last %0b end %0b",
                             got.data, got.run_last, got.stream_end));
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_byte;
  logic       out_pop;
  logic       out_empty;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_stream_end;

  lzss_decode_book_t book = new();

  int unsigned cycle_cnt   = 0;
  int unsigned fed_cnt     = 0;
  int unsigned stream_cnt  = 0;
  bit          feed_burst  = 1'b0;
  bit          drain_burst = 1'b0;
  bit          popped      = 1'b0;
  int unsigned drain_gap   = 0;
  logic [7:0]  pair_hi_next = 8'h00;

  lzss_stream_decompressor i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_byte       (in_byte),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_stream_end(out_stream_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a run that exceeds the cycle limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d decoded bytes still owed",
               cycle_cnt, book.owed_bytes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sample the result port at the rising edge; a transfer is pop with data
  // waiting.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      book.match_output(out_byte, out_run_last, out_stream_end);
      popped = 1'b1;
    end
  end

  // Drive pop at the falling edge. After every transfer draw a fresh stall,
  // and now and then switch into or out of a stretch with no stalls at all.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (popped) begin
        popped = 1'b0;
        if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
        drain_gap = drain_burst ? 0 : $urandom_range(0, 10);
      end
      if (drain_gap > 0) begin
        out_pop <= 1'b0;
        drain_gap--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Offer one compressed byte and hold it until the block takes it. Called
  // and returning at a falling edge; push only drops when a gap is drawn, so
  // back-to-back transfers keep it high.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
    gap = feed_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    book.take_byte(b);
    fed_cnt++;
    @(negedge clk);
  endtask

  // Send one whole stream: header, then flag and token bytes until the
  // tracker says the declared length is reached. Most pairs point back into
  // bytes already written so copies carry real history; the rest are raw
  // noise, which mostly lands on unwritten history. A copy-heavy stream uses
  // one literal then seven copies per flag byte, the non-noise ones longest, so
  // the window fills and slides over real data.
  task automatic send_stream(input logic [31:0] len, input bit copy_heavy);
    longint unsigned       span;
    longint unsigned       offs;
    logic [LEN_BITS-1:0]   len_bits;
    logic [15:0]           pair;
    stream_cnt++;
    for (int k = 0; k < HDR_BYTES; k++) push_byte(len[8*k +: 8]);
    while (book.next_role() != ROLE_HDR) begin
      case (book.next_role())
        ROLE_FLAG: begin
          push_byte(copy_heavy ? 8'hFE : 8'($urandom));
        end
        ROLE_LIT: begin
          push_byte(8'($urandom));
        end
        ROLE_PAIR_LO: begin
          span = (book.written > WIN_SIZE) ? WIN_SIZE : book.written;
          len_bits = copy_heavy ? '1 : LEN_BITS'($urandom);
          if (span == 0 || $urandom_range(0, 4) == 0) begin
            pair = 16'($urandom);
          end else begin
            // Favour the most recent bytes half of the time.
            if ($urandom_range(0, 1) == 1)
              offs = span - 1 - $urandom_range(0, (span > 16) ? 15 : span - 1);
            else
              offs = $urandom_range(0, span - 1);
            pair = {len_bits, win_addr_t'(offs)};
          end
          pair_hi_next = pair[15:8];
          push_byte(pair[7:0]);
        end
        default: begin
          push_byte(pair_hi_next);
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0]  seq[$];
    logic [31:0] len;
    in_push = 1'b0;
    in_byte = 8'h00;
    rst_n   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening:
    //  - an empty stream, which decodes to nothing;
    //  - a 40-byte stream: literal FF, a longest copy overlapping itself,
    //    literal 00, a copy from history not yet written (reads zero), then
    //    a longest copy cut after one byte at the declared length with the
    //    flag's remaining tokens dropped;
    //  - a one-byte stream ending on a literal.
    seq = '{8'h00, 8'h00, 8'h00, 8'h00,
            8'h28, 8'h00, 8'h00, 8'h00,
            8'h1A, 8'hFF, 8'h00, 8'hF8, 8'h00, 8'hFF, 8'h07, 8'h00, 8'hF8,
            8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5};
    foreach (seq[k]) push_byte(seq[k]);
    stream_cnt += 3;

    // One long copy-heavy stream to push the write position past the window.
    send_stream(32'($urandom_range(2100, 2300)), 1'b1);

    // Random streams, mostly short, a few empty and a few longer.
    while (fed_cnt < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = $urandom_range(100, 300);
        default: len = $urandom_range(1, 60);
      endcase
      send_stream(len, 1'b0);
    end
    in_push <= 1'b0;

    // Hold until every owed byte has come out, then watch for strays.
    while (book.owed_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d compressed bytes over %0d streams;",
             fed_cnt, stream_cnt);
    $display("checked %0d decoded bytes, %0d faults.",
             book.checked_cnt, book.fault_cnt);
    if (book.owed_bytes.size() != 0)
      $display("ERROR: %0d decoded bytes never arrived", book.owed_bytes.size());
    if (book.fault_cnt == 0 && book.owed_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/lzss_pkg.sv
design/lzss_cmd_fifo.sv
design/lzss_out_fifo.sv
design/lzss_front.sv
design/lzss_back.sv
design/lzss_stream_decompressor.sv
test/lzss_stream_decompressor_tb.sv
